// ----- src/rwms_pkg.sv -----
// Package for the rolling window mean and deviation block.
// Holds the sequencer state type and the register map constants.
// No dependencies.
package rwms_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FLUSH,
    ST_MUL,
    ST_MEAN,
    ST_VAR,
    ST_ROOT,
    ST_OUT
  } rwms_state_e;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_PARTIAL_MODE  = 1'b1;

  localparam int          WL_BITS  = 7;
  localparam logic [6:0]  WL_RESET = 7'd5;

endpackage

// ----- src/rwms_if.sv -----
// Stream interfaces for the rolling window block: sample input and result output.
// Depends on nothing; widths come from the interface parameters.
interface rwms_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          series_start;

  modport source (output valid, sample_value, series_start, input ready);
  modport sink   (input valid, sample_value, series_start, output ready);
endinterface

interface rwms_out_if #(parameter int SAMPLE_BITS = 16, parameter int COUNT_BITS = 7);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_mean;
  logic        [SAMPLE_BITS-1:0] window_sd;
  logic        [COUNT_BITS-1:0]  samples_used;

  modport source (output valid, window_mean, window_sd, samples_used, input ready);
  modport sink   (input valid, window_mean, window_sd, samples_used, output ready);
endinterface

// ----- src/rwms_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module rwms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/rwms_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies.
module rwms_div #(
  parameter int NW = 46,
  parameter int DW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   div_q, div_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The dividend shifts out at the top while quotient bits enter at the bottom.
      if (trial >= {1'b0, div_q}) begin
        rem_d = DW'(trial - {1'b0, div_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ----- src/rwms_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle (floor of root).
// No dependencies.
module rwms_sqrt #(
  parameter int W = 46
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   rad_i,
  output logic           done_o,
  output logic [W/2-1:0] root_o
);
  localparam int RW   = W / 2;
  localparam int CNTW = $clog2(RW + 1);

  logic [W-1:0]    rad_q, rad_d;
  logic [RW:0]     rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [RW+2:0]   part;
  logic [RW+2:0]   trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    part   = {rem_q, rad_q[W-1:W-2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNTW'(RW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[W-3:0], 2'b00};
      if (part >= trial) begin
        rem_d  = (RW+1)'(part - trial);
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = part[RW:0];
        root_d = {root_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ----- src/rolling_window_mean_sd.sv -----
// Rolling window mean and sample standard deviation over a sample ring.
// An item that gives a result waits on the bit-serial divider (used twice) and the serial
// root; no new input is taken until that result is loaded into the output register.
// An item that gives no result leaves the block idle and ready for the next sample.
// Reset clears the fill count and write slot; the sums and the ring are not cleared.
module rolling_window_mean_sd
  import rwms_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rwms_in_if.sink     in_i,
  rwms_out_if.source  out_o
);
  localparam int SW   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW;
  localparam int VW   = 2 * SUMW;
  localparam int DW   = 2 * CW;

  // Configuration registers
  logic [WL_BITS-1:0] wl_q;
  logic               pm_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
      pm_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WINDOW_LENGTH: wl_q <= pwdata[WL_BITS-1:0];
        REG_PARTIAL_MODE:  pm_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_LENGTH: prdata = {{(32-WL_BITS){1'b0}}, wl_q};
      REG_PARTIAL_MODE:  prdata = {31'b0, pm_q};
      default:           prdata = '0;
    endcase
  end

  // Sequencer and history state
  rwms_state_e state_q, state_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic [AW-1:0]  slot_q, slot_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  rd_cnt_q, rd_cnt_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;

  logic           accept;
  logic [CW-1:0]  weff;
  logic [CW-1:0]  fill_base;
  logic [AW-1:0]  slot_base;
  logic [CW-1:0]  fill_new;
  logic [CW-1:0]  count_new;
  logic           issue;

  assign accept = in_i.valid & in_i.ready;
  assign weff   = (int'(wl_q) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(wl_q);
  assign fill_base = in_i.series_start ? '0 : fill_q;
  assign slot_base = in_i.series_start ? '0 : slot_q;
  assign fill_new  = (fill_base < CW'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
  assign count_new = (fill_new < weff) ? fill_new : weff;
  assign issue     = (state_q == ST_SUM);

  // Ring and accumulation pipeline
  logic [SW-1:0]          ram_rdata;
  logic                   rv_q, sv_q;
  logic signed [SW-1:0]   s_q;
  logic [2*SW-1:0]        sq_q;
  logic signed [2*SW-1:0] prod;
  logic signed [SUMW-1:0] sum_q;
  logic [SQW-1:0]         sqacc_q;

  rwms_ram #(.WIDTH(SW), .DEPTH(MAX_WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && (weff != '0)),
    .waddr_i (slot_base),
    .wdata_i (in_i.sample_value),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign prod = $signed(ram_rdata) * $signed(ram_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      rv_q <= issue;
      sv_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q  <= $signed(ram_rdata);
    sq_q <= unsigned'(prod);
    if (accept) begin
      sum_q   <= '0;
      sqacc_q <= '0;
    end else if (sv_q) begin
      sum_q   <= sum_q + {{CW{s_q[SW-1]}}, s_q};
      sqacc_q <= sqacc_q + SQW'(sq_q);
    end
  end

  // Products ahead of the divisions
  logic [SUMW-1:0] mag;
  logic            neg_q;
  logic [VW-1:0]   num_q, s2_q;
  logic [DW-1:0]   den_q;
  logic            multi_q;

  assign mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FLUSH) begin
      neg_q   <= sum_q[SUMW-1];
      num_q   <= VW'(cnt_q * sqacc_q);
      s2_q    <= VW'(mag * mag);
      den_q   <= DW'(cnt_q * (cnt_q - 1'b1));
      multi_q <= (cnt_q >= CW'(2));
    end
  end

  // Shared divider and root unit
  logic            div_start, div_done;
  logic [VW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic [VW-1:0]   div_quot;
  logic            sqrt_start, sqrt_done;
  logic [SUMW-1:0] root;
  logic [VW-1:0]   var_num;

  assign var_num = (multi_q && (num_q > s2_q)) ? num_q - s2_q : '0;

  always_comb begin
    div_start = 1'b0;
    div_num   = VW'(mag);
    div_den   = DW'(cnt_q);
    if (state_q == ST_MUL) begin
      div_start = 1'b1;
    end else if (state_q == ST_MEAN && div_done) begin
      div_start = 1'b1;
      div_num   = var_num;
      div_den   = multi_q ? den_q : DW'(1);
    end
  end

  assign sqrt_start = (state_q == ST_VAR) && div_done;

  rwms_div #(.NW(VW), .DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rwms_sqrt #(.W(VW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  logic [SW-1:0] mean_q;
  logic [SW-1:0] sd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEAN && div_done) begin
      mean_q <= neg_q ? SW'(-div_quot[SUMW-1:0]) : SW'(div_quot[SUMW-1:0]);
    end
    if (sqrt_done) begin
      sd_q <= (root > SUMW'({SW{1'b1}})) ? {SW{1'b1}} : SW'(root);
    end
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    rd_cnt_d = rd_cnt_q;
    rd_ptr_d = rd_ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fill_d = fill_base;
          slot_d = slot_base;
          if (weff != '0) begin
            fill_d = fill_new;
            slot_d = (slot_base == AW'(MAX_WINDOW - 1)) ? '0 : slot_base + 1'b1;
            if ((count_new == weff) || pm_q) begin
              cnt_d    = count_new;
              rd_cnt_d = '0;
              rd_ptr_d = slot_base;
              state_d  = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        rd_cnt_d = rd_cnt_q + 1'b1;
        rd_ptr_d = (rd_ptr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr_q - 1'b1;
        if (rd_cnt_q + 1'b1 == cnt_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!rv_q && !sv_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_MEAN;
      ST_MEAN: if (div_done) state_d = ST_VAR;
      ST_VAR:  if (div_done) state_d = ST_ROOT;
      ST_ROOT: if (sqrt_done) state_d = ST_OUT;
      ST_OUT:  if (!out_o.valid || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      slot_q   <= '0;
      cnt_q    <= '0;
      rd_cnt_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      slot_q   <= slot_d;
      cnt_q    <= cnt_d;
      rd_cnt_q <= rd_cnt_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Outputs
  logic          ovalid_q, ovalid_d;
  logic          load_out;
  logic [SW-1:0] omean_q;
  logic [SW-1:0] osd_q;
  logic [CW-1:0] oused_q;

  always_comb begin
    load_out = (state_q == ST_OUT) && (!ovalid_q || out_o.ready);
    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      omean_q <= mean_q;
      osd_q   <= sd_q;
      oused_q <= cnt_q;
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.window_mean  = omean_q;
  assign out_o.window_sd    = osd_q;
  assign out_o.samples_used = oused_q;

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input ready while an item is in work");

  a_reads_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (rd_cnt_q < cnt_q))
    else $error("ring read beyond the window");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_WINDOW))
    else $error("fill count above ring depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!ovalid_q || out_o.ready))
    else $error("result overwritten before transfer");

endmodule

// ----- tb/sv/rolling_window_mean_sd_test.sv -----
// Testbench for the rolling window mean and sample deviation block.
// Drives samples and register writes, predicts each window result and compares it.
// Depends on rwms_pkg, rwms_if.sv and rolling_window_mean_sd.sv.
module rolling_window_mean_sd_test
  import rwms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               series_start;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] window_mean;
    logic [15:0]        window_sd;
    logic [6:0]         samples_used;
  } window_stat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rwms_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  rwms_out_if #(.SAMPLE_BITS(16), .COUNT_BITS(7)) out_ch ();

  rolling_window_mean_sd u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state.
  logic [6:0]         cfg_window;
  logic               cfg_partial;
  logic signed [15:0] hist [64];
  int unsigned        fill, slot;

  sample_t      pending_samples[$];
  window_stat_t expected_stats[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  hold_out = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Advances the predicted history by one accepted sample and queues its result, if any.
  task automatic predict_window(sample_t s);
    int unsigned w, cnt;
    longint sum, mag, mean;
    longint unsigned sq, num, s2, var_q, sd;
    window_stat_t e;
    w = cfg_window;
    sum = 0;
    sq = 0;
    sd = 0;
    if (s.series_start) begin
      fill = 0;
      slot = 0;
    end
    if (w == 0) return;
    if (w > 64) w = 64;
    hist[slot] = s.sample_value;
    slot = (slot + 1 >= 64) ? 0 : slot + 1;
    if (fill < 64) fill++;
    cnt = (fill < w) ? fill : w;
    for (int k = 0; k < cnt; k++) begin
      longint v;
      v = hist[(slot + 63 - k) % 64];
      sum += v;
      sq += longint'(v * v);
    end
    if (cnt < w && !cfg_partial) return;
    mean = sum / longint'(cnt);
    if (cnt >= 2) begin
      mag = (sum < 0) ? -sum : sum;
      num = longint'(cnt) * sq;
      s2 = mag * mag;
      var_q = (num > s2) ? (num - s2) / (longint'(cnt) * (cnt - 1)) : 0;
      sd = int_sqrt(var_q);
      if (sd > 64'hFFFF) sd = 64'hFFFF;
    end
    e.window_mean  = mean[15:0];
    e.window_sd    = sd[15:0];
    e.samples_used = cnt[6:0];
    expected_stats.insert(expected_stats.size(), e);
  endtask

  // Sample driver with random bursts of idling.
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.sample_value <= '0;
      in_ch.series_start <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_window(pending_samples.pop_front());
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 11);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.sample_value <= pending_samples[0].sample_value;
        in_ch.series_start <= pending_samples[0].series_start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls.
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        window_stat_t e;
        idle_cycles = 0;
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: mean %0d sd %0d used %0d",
              out_ch.window_mean, out_ch.window_sd, out_ch.samples_used);
        end else begin
          e = expected_stats.pop_front();
          if (e.window_mean !== out_ch.window_mean || e.window_sd !== out_ch.window_sd ||
              e.samples_used !== out_ch.samples_used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result differs: expected mean %0d sd %0d used %0d, got %0d %0d %0d",
                e.window_mean, e.window_sd, e.samples_used,
                out_ch.window_mean, out_ch.window_sd, out_ch.samples_used);
          end
        end
        if (!calm && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 11);
      end else if (in_ch.valid && in_ch.ready) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (hold_out) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd4 * REG_WINDOW_LENGTH) cfg_window = data[6:0];
    else cfg_partial = data[0];
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_ch.valid || expected_stats.size() > 0)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // Appends one item to the tail of the pending queue.
  task automatic append_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic sample_t rand_sample(int start_odds);
    sample_t s;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) s.sample_value = 16'sh7FFF;
    else if (pick == 1) s.sample_value = 16'sh8000;
    else if (pick < 5) s.sample_value = $urandom_range(0, 4095) - 2048;
    else s.sample_value = $urandom;
    s.series_start = ($urandom_range(0, start_odds) == 0);
    return s;
  endfunction

  task automatic add_samples(int n, int start_odds);
    repeat (n) append_sample(rand_sample(start_odds));
  endtask

  initial begin
    logic [6:0] lengths [8] = '{7'd1, 7'd64, 7'd2, 7'd0, 7'd127, 7'd3, 7'd17, 7'd8};
    cfg_window = WL_RESET;
    cfg_partial = 1'b0;
    fill = 0;
    slot = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, a series marker, full window at the reset length.
    append_sample('{16'sh7FFF, 1'b1});
    append_sample('{16'sh8000, 1'b0});
    append_sample('{16'sh7FFF, 1'b0});
    append_sample('{16'sh8000, 1'b0});
    append_sample('{16'sh0000, 1'b0});
    append_sample('{16'shFFFF, 1'b0});
    append_sample('{16'sh0001, 1'b1});
    append_sample('{16'sh0100, 1'b0});
    wait_drained();
    write_reg(3'd4 * REG_PARTIAL_MODE, 32'd1);
    append_sample('{16'sh1234, 1'b1});
    append_sample('{16'shEDCC, 1'b0});
    append_sample('{16'sh5555, 1'b0});
    wait_drained();
    // Zero length: sample dropped, marker still clears.
    write_reg(3'd4 * REG_WINDOW_LENGTH, 32'd0);
    append_sample('{16'sh0777, 1'b1});
    wait_drained();
    // Long window of extremes, then shrink mid-series.
    write_reg(3'd4 * REG_WINDOW_LENGTH, 32'd64);
    for (int i = 0; i < 6; i++) append_sample('{i[0] ? 16'sh8000 : 16'sh7FFF, 1'b0});
    wait_drained();
    write_reg(3'd4 * REG_WINDOW_LENGTH, 32'd3);
    append_sample('{16'sh0042, 1'b0});
    wait_drained();

    // Random phases over several settings.
    foreach (lengths[i]) begin
      write_reg(3'd4 * REG_WINDOW_LENGTH, {25'd0, lengths[i]});
      write_reg(3'd4 * REG_PARTIAL_MODE, {31'd0, i[0]});
      if (i == 2) begin
        // Receiver holds off while the sender keeps offering.
        fork
          begin
            hold_out = 1'b1;
            repeat (800) @(posedge clk_i);
            hold_out = 1'b0;
          end
        join_none
      end
      if (i == 7) calm = 1'b1;
      add_samples(70, (lengths[i] > 16) ? 60 : 20);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
